@@ rtl/c7fc_pkg.sv @@
// Package for the CRC7 frame checker: item types, frame positions and the
// byte-wide CRC7 update function. Depends on nothing else.
package c7fc_pkg;

    // Frame layout. The frame length is fixed at 16 bytes.
    localparam int FRAME_BYTES = 16;
    localparam int POS_W = 4;

    localparam logic [POS_W-1:0] CMD_FIRST = POS_W'(10);
    localparam logic [POS_W-1:0] CMD_LAST  = POS_W'(12);
    localparam logic [POS_W-1:0] CMD_CHECK = POS_W'(13);
    localparam logic [POS_W-1:0] DATA_LAST = POS_W'(14);
    localparam logic [POS_W-1:0] FRAME_END = POS_W'(FRAME_BYTES - 1);

    // CRC7 generator x^7 + x^3 + 1 without its top term.
    localparam logic [6:0] POLY7 = 7'h09;

    // One input item.
    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] module_number;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic [7:0] module_tag;
        logic       cmd_crc_ok;
        logic       data_crc_ok;
        logic       frame_ok;
    } out_item_t;

    // Status of the frame tracker, seen by the top level.
    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             take;
        logic             last;
    } track_stat_t;

    // Shifts one byte into a CRC7 register, most significant bit first.
    function automatic logic [6:0] crc7_byte(input logic [6:0] crc_in,
                                             input logic [7:0] data);
        logic [6:0] crc;
        logic       fb;
        crc = crc_in;
        for (int i = 7; i >= 0; i--)
        begin
            fb  = crc[6] ^ data[i];
            crc = {crc[5:0], 1'b0};
            if (fb)
            begin
                crc = crc ^ POLY7;
            end
        end
        return crc;
    endfunction

endpackage

@@ rtl/c7fc_if.sv @@
// Valid/ready channel interfaces for the CRC7 frame checker.
// Depends on nothing; carries the byte stream and the result stream.
interface c7fc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic [7:0] module_number;

    modport source (output valid, output data_byte, output module_number, input ready);
    modport sink   (input valid, input data_byte, input module_number, output ready);
endinterface

interface c7fc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] module_tag;
    logic       cmd_crc_ok;
    logic       data_crc_ok;
    logic       frame_ok;

    modport source (output valid, output module_tag, output cmd_crc_ok,
                    output data_crc_ok, output frame_ok, input ready);
    modport sink   (input valid, input module_tag, input cmd_crc_ok,
                    input data_crc_ok, input frame_ok, output ready);
endinterface

@@ rtl/c7fc_in_stage.sv @@
// Input register of the CRC7 frame checker.
// Depends on c7fc_pkg and c7fc_in_if.
module c7fc_in_stage
    import c7fc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    c7fc_in_if.sink       bytes,
    input  logic          take,
    output logic          item_valid,
    output in_item_t      item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     accept;

    // The register takes a new item when it is empty or its item moves on.
    assign bytes.ready = !valid_reg || take;
    assign accept      = bytes.valid && bytes.ready;

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.data_byte     <= bytes.data_byte;
            item_reg.module_number <= bytes.module_number;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

@@ rtl/c7fc_frame_track.sv @@
// Frame tracker: byte position, command and data CRC7 registers, and checks.
// Depends on c7fc_pkg.
module c7fc_frame_track
    import c7fc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  in_item_t    item,
    input  logic        out_room,
    output track_stat_t stat,
    output out_item_t   result
);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [6:0]       data_rem_reg;
    logic [6:0]       data_rem_next;
    logic [6:0]       cmd_rem_reg;
    logic [6:0]       cmd_rem_next;
    logic             cmd_pass_reg;
    logic             cmd_pass_next;
    logic             last;
    logic             take;
    logic             data_pass;

    // An item at the last byte moves on only when the result register has room.
    assign last = (pos_reg == FRAME_END);
    assign take = item_valid && (!last || out_room);

    assign data_pass = (item.data_byte == {data_rem_reg, 1'b1});

    // Next state of the frame.
    always_comb
    begin
        pos_next      = pos_reg;
        data_rem_next = data_rem_reg;
        cmd_rem_next  = cmd_rem_reg;
        cmd_pass_next = cmd_pass_reg;
        if (take)
        begin
            if (last)
            begin
                pos_next      = '0;
                data_rem_next = '0;
                cmd_rem_next  = '0;
                cmd_pass_next = 1'b0;
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
                if (pos_reg <= DATA_LAST)
                begin
                    data_rem_next = crc7_byte(data_rem_reg, item.data_byte);
                end
                if (pos_reg >= CMD_FIRST && pos_reg <= CMD_LAST)
                begin
                    cmd_rem_next = crc7_byte(cmd_rem_reg, item.data_byte);
                end
                if (pos_reg == CMD_CHECK)
                begin
                    cmd_pass_next = (item.data_byte == {cmd_rem_reg, 1'b1});
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            data_rem_reg <= '0;
            cmd_rem_reg  <= '0;
            cmd_pass_reg <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            data_rem_reg <= data_rem_next;
            cmd_rem_reg  <= cmd_rem_next;
            cmd_pass_reg <= cmd_pass_next;
        end
    end

    // Result built from the last byte of the frame.
    always_comb
    begin
        result.module_tag  = item.module_number;
        result.cmd_crc_ok  = cmd_pass_reg;
        result.data_crc_ok = data_pass;
        result.frame_ok    = cmd_pass_reg && data_pass;
    end

    assign stat.pos  = pos_reg;
    assign stat.take = take;
    assign stat.last = last;

endmodule

@@ rtl/crc7_frame_checker_core.sv @@
// Top level of the CRC7 frame checker: input register, frame tracker and
// result register. Depends on c7fc_pkg, c7fc_if, c7fc_in_stage, c7fc_frame_track.
//
// Bytes of 16-byte module frames enter on "bytes", one item per cycle unless
// stalled. The command CRC7 (x^7+x^3+1, zero start, MSB first) over bytes 10
// to 12 is checked against byte 13 and the data CRC7 over bytes 0 to 14 against
// byte 15; a check byte passes when it equals the CRC shifted left with its low
// bit set. Byte 15 of each frame yields one item on "results" with both flags,
// their AND and that byte's module number. There is no resynchronization: the
// position only counts bytes from reset. A result passes through the input
// register and then the result register. Only a byte 15 that finds the result
// register still full waits, so a held result stalls input at most at that byte.
module crc7_frame_checker_core
    import c7fc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    c7fc_in_if.sink    bytes,
    c7fc_out_if.source results
);

    logic        item_valid;
    in_item_t    item;
    track_stat_t stat;
    out_item_t   result;
    logic        out_room;
    logic        load;
    logic        out_valid_reg;
    logic        out_valid_next;
    out_item_t   out_item_reg;

    c7fc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .bytes      (bytes),
        .take       (stat.take),
        .item_valid (item_valid),
        .item       (item)
    );

    c7fc_frame_track u_frame_track (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .out_room   (out_room),
        .stat       (stat),
        .result     (result)
    );

    // Result register: room when empty or being emptied this cycle.
    assign out_room = !out_valid_reg || results.ready;
    assign load     = stat.take && stat.last;

    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_item_reg <= result;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.module_tag  = out_item_reg.module_tag;
    assign results.cmd_crc_ok  = out_item_reg.cmd_crc_ok;
    assign results.data_crc_ok = out_item_reg.data_crc_ok;
    assign results.frame_ok    = out_item_reg.frame_ok;

    // A finished frame always shows a result in the next cycle.
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> results.valid)
        else $error("frame end did not produce a result");

    // The position wraps to the first byte after the frame end.
    a_pos_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (stat.pos == '0))
        else $error("byte position did not wrap after frame end");

    // An empty input register always takes a byte.
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !item_valid |-> bytes.ready)
        else $error("input stalled while its register was empty");

    // A held byte waits only for a full result register at the frame end.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !stat.take) |-> (stat.last && results.valid && !results.ready))
        else $error("byte stalled without a blocked result");

endmodule

@@ bench/tb_crc7_frame_checker_core.sv @@
`timescale 1ns / 100ps
// Self-checking bench for crc7_frame_checker_core: 16-byte frames with good and bad CRC7
// check bytes, random gaps on input and output, results checked against a frame tracker.
// Depends on c7fc_pkg, c7fc_if and the RTL of crc7_frame_checker_core.
module tb_crc7_frame_checker_core;
    import c7fc_pkg::*;

    localparam int RANDOM_FRAMES = 94;
    localparam int IDLE_LIMIT    = 2000;
    localparam int DRAIN_CYCLES  = 12;

    logic clk;
    logic rst_n;

    c7fc_in_if  bytes_if ();
    c7fc_out_if res_if ();

    crc7_frame_checker_core DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (bytes_if.sink),
        .results (res_if.source)
    );

    // Bytes waiting to be offered, and verdicts waiting to come out.
    in_item_t  pending_bytes[$];
    out_item_t expected_verdicts[$];

    int unsigned bytes_total;
    int unsigned bytes_taken;
    int unsigned error_count;
    int unsigned idle_cycles;

    // Frame tracker: position and running remainders of the current frame.
    logic [POS_W-1:0] frame_pos;
    logic [6:0]       data_rem;
    logic [6:0]       cmd_rem;
    logic             cmd_ok;

    // Gap and stall control for both sides.
    int unsigned gap_left;
    int unsigned stall_left;
    bit          calm_in;
    bit          calm_out;

    // CRC7, x^7 + x^3 + 1, one byte shifted in from the top bit down.
    function automatic logic [6:0] crc7_shift(input logic [6:0] rem, input logic [7:0] b);
        logic [6:0] r;
        logic       top;
        r = rem;
        for (int k = 7; k >= 0; k--)
        begin
            top = r[6] ^ b[k];
            r   = {r[5:0], 1'b0} ^ (top ? 7'h09 : 7'h00);
        end
        return r;
    endfunction

    // Idle length: mostly none or short, a few long, none at all in a calm stretch.
    function automatic int unsigned pick_gap(input bit calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 30);
    endfunction

    // Check byte that must never pass: the correct value with one bit flipped.
    function automatic logic [7:0] spoil(input logic [7:0] good);
        return good ^ (8'h01 << $urandom_range(0, 7));
    endfunction

    // Advances the frame tracker by one accepted byte; byte 15 yields a verdict.
    task automatic track_byte(input in_item_t it);
        out_item_t v;
        logic      data_ok;
        if (frame_pos <= DATA_LAST)
        begin
            data_rem = crc7_shift(data_rem, it.data_byte);
        end
        if (frame_pos >= CMD_FIRST && frame_pos <= CMD_LAST)
        begin
            cmd_rem = crc7_shift(cmd_rem, it.data_byte);
        end
        if (frame_pos == CMD_CHECK)
        begin
            cmd_ok = (it.data_byte == {cmd_rem, 1'b1});
        end
        if (frame_pos == FRAME_END)
        begin
            data_ok       = (it.data_byte == {data_rem, 1'b1});
            v.module_tag  = it.module_number;
            v.cmd_crc_ok  = cmd_ok;
            v.data_crc_ok = data_ok;
            v.frame_ok    = cmd_ok & data_ok;
            expected_verdicts.push_back(v);
            data_rem  = '0;
            cmd_rem   = '0;
            cmd_ok    = 1'b0;
            frame_pos = '0;
        end
        else
        begin
            frame_pos = frame_pos + 1'b1;
        end
    endtask

    // Queues one frame; the check bytes are correct or spoiled as asked.
    task automatic queue_frame(input bit good_cmd, input bit good_data,
                               input logic [7:0] fill, input logic [7:0] noise_mod,
                               input logic [7:0] tag, input bit random_fill);
        logic [7:0] fb[FRAME_BYTES];
        logic [6:0] rem;
        in_item_t   it;
        for (int i = 0; i < FRAME_BYTES; i++)
        begin
            if (!random_fill)
            begin
                fb[i] = fill;
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                fb[i] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            else
            begin
                fb[i] = 8'($urandom_range(0, 255));
            end
        end
        // Command check byte over bytes 10 to 12.
        rem = '0;
        for (int i = CMD_FIRST; i <= CMD_LAST; i++)
        begin
            rem = crc7_shift(rem, fb[i]);
        end
        fb[CMD_CHECK] = good_cmd ? {rem, 1'b1} : spoil({rem, 1'b1});
        // Data check byte over bytes 0 to 14.
        rem = '0;
        for (int i = 0; i <= DATA_LAST; i++)
        begin
            rem = crc7_shift(rem, fb[i]);
        end
        fb[FRAME_END] = good_data ? {rem, 1'b1} : spoil({rem, 1'b1});
        for (int i = 0; i < FRAME_BYTES; i++)
        begin
            it.data_byte     = fb[i];
            it.module_number = (i == FRAME_END) ? tag :
                               (random_fill ? 8'($urandom_range(0, 255)) : noise_mod);
            pending_bytes.push_back(it);
        end
    endtask

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // Byte driver: offers queued items with random gaps in between.
    always @(posedge clk)
    begin : drive_bytes
        logic     nv;
        in_item_t nx;
        if (!rst_n)
        begin
            bytes_if.valid         <= 1'b0;
            bytes_if.data_byte     <= 8'h00;
            bytes_if.module_number <= 8'h00;
        end
        else
        begin
            nv = bytes_if.valid;
            nx.data_byte     = bytes_if.data_byte;
            nx.module_number = bytes_if.module_number;
            if (bytes_if.valid && bytes_if.ready)
            begin
                track_byte(nx);
                bytes_taken++;
                nv = 1'b0;
            end
            if (!nv)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (pending_bytes.size() > 0)
                begin
                    nx = pending_bytes.pop_front();
                    nv = 1'b1;
                    if ($urandom_range(0, 63) == 0)
                    begin
                        calm_in = !calm_in;
                    end
                    gap_left = pick_gap(calm_in);
                end
            end
            bytes_if.valid         <= nv;
            bytes_if.data_byte     <= nx.data_byte;
            bytes_if.module_number <= nx.module_number;
        end
    end

    // Result monitor: checks each accepted item and stalls ready at random.
    always @(posedge clk)
    begin : watch_results
        out_item_t got;
        out_item_t want;
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
        end
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                got.module_tag  = res_if.module_tag;
                got.cmd_crc_ok  = res_if.cmd_crc_ok;
                got.data_crc_ok = res_if.data_crc_ok;
                got.frame_ok    = res_if.frame_ok;
                if (expected_verdicts.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected result tag=%0d cmd=%b data=%b frame=%b",
                             $time, got.module_tag, got.cmd_crc_ok, got.data_crc_ok,
                             got.frame_ok);
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (got !== want)
                    begin
                        error_count++;
                        $display("%0t: mismatch expected tag=%0d cmd=%b data=%b frame=%b",
                                 $time, want.module_tag, want.cmd_crc_ok,
                                 want.data_crc_ok, want.frame_ok);
                        $display("%0t:          actual   tag=%0d cmd=%b data=%b frame=%b",
                                 $time, got.module_tag, got.cmd_crc_ok,
                                 got.data_crc_ok, got.frame_ok);
                    end
                end
            end
            // Ready drops for a random stretch now and then.
            if (stall_left > 0)
            begin
                stall_left--;
                res_if.ready <= 1'b0;
            end
            else
            begin
                if ($urandom_range(0, 127) == 0)
                begin
                    calm_out = !calm_out;
                end
                if ($urandom_range(0, 3) == 0)
                begin
                    stall_left = pick_gap(calm_out);
                end
                res_if.ready <= (stall_left == 0);
            end
        end
    end

    // Watchdog: ends the run when no item moves on either side for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((bytes_if.valid && bytes_if.ready) || (res_if.valid && res_if.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAIL crc7_frame_checker_core");
                $finish;
            end
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        bytes_if.valid         = 1'b0;
        bytes_if.data_byte     = 8'h00;
        bytes_if.module_number = 8'h00;
        res_if.ready           = 1'b0;
        rst_n       = 1'b0;
        frame_pos   = '0;
        data_rem    = '0;
        cmd_rem     = '0;
        cmd_ok      = 1'b0;
        gap_left    = 0;
        stall_left  = 0;
        calm_in     = 1'b0;
        calm_out    = 1'b0;
        bytes_taken = 0;
        error_count = 0;
        idle_cycles = 0;

        // Directed: all-ones frame with both checks good and tag zero, then an
        // all-zero frame whose check bytes lack the low bit, so both checks fail.
        queue_frame(1'b1, 1'b1, 8'hFF, 8'hFF, 8'h00, 1'b0);
        queue_frame(1'b0, 1'b0, 8'h00, 8'h00, 8'hFF, 1'b0);
        pending_bytes[CMD_CHECK + FRAME_BYTES].data_byte = 8'h00;
        pending_bytes[FRAME_END + FRAME_BYTES].data_byte = 8'h00;

        // Random frames: mostly correct check bytes, some spoiled on either side.
        for (int f = 0; f < RANDOM_FRAMES; f++)
        begin
            queue_frame($urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0,
                        8'h00, 8'h00, 8'($urandom_range(0, 255)), 1'b1);
        end
        bytes_total = pending_bytes.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every byte to be taken and every verdict to come out.
        while (bytes_taken != bytes_total)
        begin
            @(posedge clk);
        end
        while (expected_verdicts.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
        begin
            $display("PASS crc7_frame_checker_core");
        end
        else
        begin
            $display("FAIL crc7_frame_checker_core");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/c7fc_pkg.sv
rtl/c7fc_if.sv
rtl/c7fc_in_stage.sv
rtl/c7fc_frame_track.sv
rtl/crc7_frame_checker_core.sv
bench/tb_crc7_frame_checker_core.sv
